[design/assert_macros.svh]
// Assertion macros shared by the parser modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Check that a condition never holds
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed");
`endif

[design/lwob_pkg.sv]
// Package for the LWOB mesh stream parser: types, codes and constants
`default_nettype none
package lwob_pkg;
	localparam int LENGTH_BITS = 24;
	localparam logic [31:0] TAG_FORM = 32'h464F524D;
	localparam logic [31:0] TAG_LWOB = 32'h4C574F42;
	localparam logic [31:0] TAG_PNTS = 32'h504E5453;
	localparam logic [31:0] TAG_POLS = 32'h504F4C53;
	localparam logic [15:0] DETAIL_SURFACE = 16'h8000;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_DATA = 1'b1;

	localparam logic [1:0] KIND_VERTEX = 2'd0;
	localparam logic [1:0] KIND_TRIANGLE = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_TOO_SMALL = 3'd1;
	localparam logic [2:0] ST_NO_FORM = 3'd2;
	localparam logic [2:0] ST_BAD_TYPE = 3'd3;
	localparam logic [2:0] ST_CORRUPT = 3'd4;
	localparam logic [2:0] ST_NO_GEOM = 3'd5;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = 2;

	typedef enum logic [3:0] {
		PH_IDLE, PH_HEADER, PH_CHUNK_HDR, PH_PNTS, PH_POLS_COUNT, PH_POLS_INDEX,
		PH_POLS_SURF, PH_DETAIL_COUNT, PH_DETAIL_EDGE, PH_DETAIL_SKIP, PH_SKIP,
		PH_PAD, PH_TAIL, PH_ERROR
	} phase_t;

	typedef struct packed {
		logic cmd;
		logic [23:0] value;
	} in_word_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [31:0] x_bits;
		logic [31:0] y_bits;
		logic [31:0] z_bits;
		logic [15:0] corner_a;
		logic [15:0] corner_b;
		logic [15:0] corner_c;
		logic [2:0] status;
		logic last_of_run;
	} out_word_t;

	// Classified byte passed from the front to the back
	typedef struct packed {
		logic start;
		logic [LENGTH_BITS-1:0] len;
		logic [7:0] data;
	} cls_word_t;

	// Result pair produced by the back for one byte
	typedef struct packed {
		logic [1:0] count;
		out_word_t r0;
		out_word_t r1;
	} res_pair_t;
endpackage
`default_nettype wire

[design/lwob_mesh_stream_parser.sv]
// Top level of the LWOB mesh stream parser
// Usage: the input channel takes words of {cmd, value}. A start word (cmd 0)
// carries the file length; each data word (cmd 1) carries one byte in bits 7..0.
// The output channel gives vertices, fan triangles and a final status word;
// last_of_run marks the final result that one input word caused.
// Path: an accepted word is written into the four-entry queue, the parser reads
// it from there, and its results are registered in the output pair register.
// Throughput: one input word per cycle while each byte yields at most one
// result and the receiver does not stall; a byte that yields two results (the
// last byte of a file) holds the parser until the single output register has delivered both.
// Reset clears the queue, parser state and output register; the block then
// waits for a start word. When the receiver stalls, the output word holds,
// the queue fills, and the input stall rises once the queue is full.
`default_nettype none
module lwob_mesh_stream_parser import lwob_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire in_word_t in_word,
	output logic out_valid,
	input wire logic out_stall,
	output out_word_t out_word
);
	logic push, full, pop, empty;
	cls_word_t push_word, head;

	lwob_front u_front (
		.in_valid(in_valid), .in_stall(in_stall),
		.in_word(in_word), .push(push), .push_word(push_word), .full(full)
	);

	lwob_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_word(push_word),
		.full(full), .pop(pop), .empty(empty), .head(head)
	);

	lwob_back u_back (
		.clk(clk), .arst_n(arst_n), .empty(empty), .head(head), .pop(pop),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
	);
endmodule
`default_nettype wire

[design/lwob_front.sv]
// Front part: accepts input words, masks them and pushes them into the queue
`default_nettype none
module lwob_front import lwob_pkg::*; (
	input wire logic in_valid,
	output logic in_stall,
	input wire in_word_t in_word,
	output logic push,
	output cls_word_t push_word,
	input wire logic full
);
	// Stall while the queue is full
	assign in_stall = full;
	assign push = in_valid && !full;
	always_comb begin
		push_word.start = (in_word.cmd == CMD_START);
		push_word.len = in_word.value[LENGTH_BITS-1:0];
		push_word.data = in_word.value[7:0];
	end
endmodule
`default_nettype wire

[design/lwob_queue.sv]
// Short queue between the front and back parts
`default_nettype none
`include "assert_macros.svh"
module lwob_queue import lwob_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire cls_word_t push_word,
	output logic full,
	input wire logic pop,
	output logic empty,
	output cls_word_t head
);
	cls_word_t mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q, rd_q;
	logic [QUEUE_AW:0] cnt_q;

	assign full = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head = mem_q[rd_q];

	// Store incoming word
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_word;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
		end
	end

	`ASSERT_NEVER(a_no_overflow, clk, arst_n, push && full)
	`ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && empty)
	`ASSERT_IMPL(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= (QUEUE_AW+1)'(QUEUE_DEPTH))
endmodule
`default_nettype wire

[design/lwob_back.sv]
// Back part: parser state machine, result pair register and output sequencing
`default_nettype none
`include "assert_macros.svh"
module lwob_back import lwob_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic empty,
	input wire cls_word_t head,
	output logic pop,
	output logic out_valid,
	input wire logic out_stall,
	output out_word_t out_word
);
	localparam int PW = LENGTH_BITS + 1;

	phase_t phase_q, phase_d;
	logic [LENGTH_BITS-1:0] total_q, total_d, pos_q, pos_d;
	logic [31:0] tag_q, tag_d, clen_q, clen_d;
	logic [PW-1:0] cend_q, cend_d;
	logic [31:0] ab0_q, ab0_d, ab1_q, ab1_d, ab2_q, ab2_d;
	logic [15:0] ecnt_q, ecnt_d, eidx_q, eidx_d, first_q, first_d, prev_q, prev_d;
	logic [15:0] drem_q, drem_d;
	logic [17:0] skip_q, skip_d;
	logic vseen_q, vseen_d, tseen_q, tseen_d;
	logic odd_q, odd_d;

	// Output holding: a pair of results and a pointer
	res_pair_t pair_q, pair_d;
	logic sel_q;
	logic busy;
	logic take;

	assign busy = (pair_q.count != 2'd0);
	assign out_valid = busy;
	assign out_word = sel_q ? pair_q.r1 : pair_q.r0;
	// Take a new byte when no result is pending or the last is leaving
	assign take = !empty && (!busy ||
		(!out_stall && (pair_q.count == 2'd1 || sel_q)));
	assign pop = take;

	function automatic out_word_t mk(input logic [1:0] k, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] z, input logic [15:0] a,
			input logic [15:0] b, input logic [15:0] c, input logic [2:0] st);
		out_word_t r;
		r.kind = k; r.x_bits = x; r.y_bits = y; r.z_bits = z;
		r.corner_a = a; r.corner_b = b; r.corner_c = c; r.status = st;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	// Compute next parser state and results for the head byte
	always_comb begin
		logic [PW-1:0] np, need;
		logic [15:0] w;
		logic [7:0] b;
		out_word_t r;
		logic [3:0] ei;
		logic has;
		phase_d = phase_q; total_d = total_q; pos_d = pos_q; tag_d = tag_q;
		clen_d = clen_q; cend_d = cend_q; ab0_d = ab0_q; ab1_d = ab1_q; ab2_d = ab2_q;
		ecnt_d = ecnt_q; eidx_d = eidx_q; first_d = first_q; prev_d = prev_q;
		drem_d = drem_q; skip_d = skip_q; vseen_d = vseen_q; tseen_d = tseen_q;
		odd_d = odd_q;
		pair_d.count = 2'd0;
		pair_d.r0 = '0;
		pair_d.r1 = '0;
		b = head.data;
		w = {ab0_q[7:0], b};
		np = {1'b0, pos_q} + 1'b1;
		need = '0; r = '0; ei = '0; has = 1'b0;
		if (head.start) begin
			phase_d = PH_HEADER; total_d = head.len; pos_d = '0; tag_d = '0;
			clen_d = '0; cend_d = '0; ab0_d = '0; ab1_d = '0; ab2_d = '0;
			ecnt_d = '0; eidx_d = '0; first_d = '0; prev_d = '0; drem_d = '0;
			skip_d = '0; vseen_d = 1'b0; tseen_d = 1'b0; odd_d = 1'b0;
			if (head.len < LENGTH_BITS'(12)) begin
				phase_d = PH_IDLE;
				r = mk(KIND_STATUS, '0, '0, '0, '0, '0, '0, ST_TOO_SMALL);
				has = 1'b1;
			end
		end else if (phase_q != PH_IDLE) begin
			unique case (phase_q)
				PH_HEADER: begin
					ab0_d = {ab0_q[23:0], b};
					if (pos_q == LENGTH_BITS'(3) && ab0_d != TAG_FORM) begin
						r = mk(KIND_STATUS, '0, '0, '0, '0, '0, '0, ST_NO_FORM);
						has = 1'b1; phase_d = PH_ERROR;
					end else if (pos_q == LENGTH_BITS'(11)) begin
						if (ab0_d != TAG_LWOB) begin
							r = mk(KIND_STATUS, '0, '0, '0, '0, '0, '0, ST_BAD_TYPE);
							has = 1'b1; phase_d = PH_ERROR;
						end else if (np + PW'(8) <= {1'b0, total_q}) begin
							phase_d = PH_CHUNK_HDR; eidx_d = '0;
						end else phase_d = PH_TAIL;
					end
				end
				PH_CHUNK_HDR: begin
					if (eidx_q < 16'd4) tag_d = {tag_q[23:0], b};
					else clen_d = {clen_q[23:0], b};
					eidx_d = eidx_q + 1'b1;
					if (eidx_d >= 16'd8) begin
						eidx_d = '0;
						odd_d = 1'b0;
						if (clen_d[31:LENGTH_BITS] != '0 ||
								np + {1'b0, clen_d[LENGTH_BITS-1:0]} > {1'b0, total_q}) begin
							r = mk(KIND_STATUS, '0, '0, '0, '0, '0, '0, ST_CORRUPT);
							has = 1'b1; phase_d = PH_ERROR;
						end else begin
							cend_d = np + {1'b0, clen_d[LENGTH_BITS-1:0]};
							if (tag_q[23:0] == TAG_PNTS[31:8] && b == TAG_PNTS[7:0] &&
									eidx_q == 16'd3) phase_d = PH_PNTS;
							else if (tag_d == TAG_PNTS) phase_d = PH_PNTS;
							else if (tag_d == TAG_POLS) phase_d = PH_POLS_COUNT;
							else phase_d = PH_SKIP;
						end
					end
				end
				PH_PNTS: begin
					ei = (eidx_q >= 16'd12) ? 4'd0 : eidx_q[3:0];
					if (ei[3:2] == 2'd0) ab0_d = {ab0_q[23:0], b};
					else if (ei[3:2] == 2'd1) ab1_d = {ab1_q[23:0], b};
					else ab2_d = {ab2_q[23:0], b};
					eidx_d = 16'(ei) + 1'b1;
					if (eidx_d == 16'd12) begin
						r = mk(KIND_VERTEX, ab0_d, ab1_d ^ 32'h80000000, ab2_d,
							'0, '0, '0, ST_OK);
						has = 1'b1; vseen_d = 1'b1; eidx_d = '0;
					end
				end
				PH_POLS_COUNT: begin
					if (!odd_q) ab0_d = {24'd0, b};
					else begin
						need = np + PW'({w, 1'b0}) + PW'(2);
						if (w < 16'd3 || need > cend_q || need < np) phase_d = PH_SKIP;
						else begin
							ecnt_d = w; eidx_d = '0; phase_d = PH_POLS_INDEX;
						end
					end
				end
				PH_POLS_INDEX: begin
					if (!odd_q) ab0_d = {24'd0, b};
					else begin
						if (eidx_q == 16'd0) first_d = w;
						else if (eidx_q == 16'd1) prev_d = w;
						else begin
							r = mk(KIND_TRIANGLE, '0, '0, '0, first_q, prev_q, w, ST_OK);
							has = 1'b1; tseen_d = 1'b1; prev_d = w;
						end
						eidx_d = eidx_q + 1'b1;
						if (eidx_d >= ecnt_q) phase_d = PH_POLS_SURF;
					end
				end
				PH_POLS_SURF: begin
					if (!odd_q) ab0_d = {24'd0, b};
					else phase_d = (w >= DETAIL_SURFACE) ? PH_DETAIL_COUNT : PH_POLS_COUNT;
				end
				PH_DETAIL_COUNT: begin
					if (!odd_q) ab0_d = {24'd0, b};
					else begin
						drem_d = w;
						phase_d = (w != '0) ? PH_DETAIL_EDGE : PH_POLS_COUNT;
					end
				end
				PH_DETAIL_EDGE: begin
					if (!odd_q) ab0_d = {24'd0, b};
					else begin
						skip_d = {1'b0, w, 1'b0} + 18'd2;
						phase_d = PH_DETAIL_SKIP;
					end
				end
				PH_DETAIL_SKIP: begin
					skip_d = (skip_q != '0) ? skip_q - 1'b1 : skip_q;
					if (skip_d == '0) begin
						drem_d = (drem_q != '0) ? drem_q - 1'b1 : drem_q;
						phase_d = (drem_d != '0) ? PH_DETAIL_EDGE : PH_POLS_COUNT;
					end
				end
				PH_PAD: begin
					if (np + PW'(8) <= {1'b0, total_q}) begin
						phase_d = PH_CHUNK_HDR; eidx_d = '0;
					end else phase_d = PH_TAIL;
				end
				default: begin
				end
			endcase
			// Track parity of the offset within the chunk data
			odd_d = (phase_q == PH_CHUNK_HDR) ? odd_d : !odd_q;
			// Close the chunk at its end
			if (phase_d >= PH_PNTS && phase_d <= PH_SKIP && np >= cend_d) begin
				if (clen_d[0]) phase_d = PH_PAD;
				else if (np + PW'(8) <= {1'b0, total_q}) begin
					phase_d = PH_CHUNK_HDR; eidx_d = '0;
				end else phase_d = PH_TAIL;
			end
			pos_d = np[LENGTH_BITS-1:0];
			if (np >= {1'b0, total_q}) begin
				if (phase_d != PH_ERROR) begin
					if (has) begin
						pair_d.r0 = r;
						pair_d.r1 = mk(KIND_STATUS, '0, '0, '0, '0, '0, '0,
							(vseen_d && tseen_d) ? ST_OK : ST_NO_GEOM);
						pair_d.r1.last_of_run = 1'b1;
						pair_d.count = 2'd2;
						has = 1'b0;
					end else begin
						r = mk(KIND_STATUS, '0, '0, '0, '0, '0, '0,
							(vseen_d && tseen_d) ? ST_OK : ST_NO_GEOM);
						has = 1'b1;
					end
				end
				phase_d = PH_IDLE;
			end
		end
		if (has) begin
			pair_d.r0 = r;
			pair_d.r0.last_of_run = 1'b1;
			pair_d.count = 2'd1;
		end
	end

	// Hold parser state, update on each taken byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			total_q <= '0; pos_q <= '0; tag_q <= '0; clen_q <= '0; cend_q <= '0;
			ab0_q <= '0; ab1_q <= '0; ab2_q <= '0; ecnt_q <= '0; eidx_q <= '0;
			first_q <= '0; prev_q <= '0; drem_q <= '0; skip_q <= '0;
			vseen_q <= 1'b0; tseen_q <= 1'b0; odd_q <= 1'b0;
		end else if (take) begin
			phase_q <= phase_d;
			total_q <= total_d; pos_q <= pos_d; tag_q <= tag_d; clen_q <= clen_d;
			cend_q <= cend_d; ab0_q <= ab0_d; ab1_q <= ab1_d; ab2_q <= ab2_d;
			ecnt_q <= ecnt_d; eidx_q <= eidx_d; first_q <= first_d; prev_q <= prev_d;
			drem_q <= drem_d; skip_q <= skip_d; vseen_q <= vseen_d; tseen_q <= tseen_d;
			odd_q <= odd_d;
		end
	end

	// Hold results until delivered, advance pointer on each handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q <= '0;
			sel_q <= 1'b0;
		end else if (take) begin
			pair_q <= pair_d;
			sel_q <= 1'b0;
		end else if (busy && !out_stall) begin
			if (pair_q.count == 2'd2 && !sel_q) sel_q <= 1'b1;
			else begin
				pair_q.count <= 2'd0;
				sel_q <= 1'b0;
			end
		end
	end

	`ASSERT_IMPL(a_sel_pair, clk, arst_n, sel_q, pair_q.count == 2'd2)
	`ASSERT_IMPL(a_take_free, clk, arst_n, take && busy, !out_stall)
	`ASSERT_NEVER(a_count_range, clk, arst_n, pair_q.count == 2'd3)
endmodule
`default_nettype wire
